// ===== sv/typed_integer_alu_unit_macros.svh =====
// Assertion macros for the typed integer ALU unit
`ifndef TYPED_INTEGER_ALU_UNIT_MACROS_SVH
`define TYPED_INTEGER_ALU_UNIT_MACROS_SVH

// check a property outside reset
`define TAI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every edge, reset included
`define TAI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/tai_pkg.sv =====
// Types, codes and helper functions shared by the typed integer ALU
package tai_pkg;

    typedef struct packed {
        logic [4:0]  op;
        logic [1:0]  a_type;
        logic [1:0]  b_type;
        logic [1:0]  dest_type;
        logic [63:0] a_value;
        logic [63:0] b_value;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_value;
        logic        status;
    } out_item_t;

    localparam logic [4:0] OP_ASSIGN  = 5'd0;
    localparam logic [4:0] OP_CAST    = 5'd1;
    localparam logic [4:0] OP_ZEXT    = 5'd2;
    localparam logic [4:0] OP_SEXT    = 5'd3;
    localparam logic [4:0] OP_TRUNC   = 5'd4;
    localparam logic [4:0] OP_NEG     = 5'd5;
    localparam logic [4:0] OP_ABS     = 5'd6;
    localparam logic [4:0] OP_NOT     = 5'd7;
    localparam logic [4:0] OP_BSWAP   = 5'd8;
    localparam logic [4:0] OP_ISTRUE  = 5'd9;
    localparam logic [4:0] OP_ISFALSE = 5'd10;
    localparam logic [4:0] OP_ADD     = 5'd11;
    localparam logic [4:0] OP_SUB     = 5'd12;
    localparam logic [4:0] OP_MUL     = 5'd13;
    localparam logic [4:0] OP_UDIV    = 5'd14;
    localparam logic [4:0] OP_AND     = 5'd15;
    localparam logic [4:0] OP_ANDNOT  = 5'd16;
    localparam logic [4:0] OP_OR      = 5'd17;
    localparam logic [4:0] OP_XOR     = 5'd18;
    localparam logic [4:0] OP_SHL     = 5'd19;
    localparam logic [4:0] OP_SHR     = 5'd20;
    localparam logic [4:0] OP_SHA     = 5'd21;
    localparam logic [4:0] OP_EQ      = 5'd22;
    localparam logic [4:0] OP_NE      = 5'd23;
    localparam logic [4:0] OP_SLT     = 5'd24;
    localparam logic [4:0] OP_SLE     = 5'd25;
    localparam logic [4:0] OP_SGT     = 5'd26;
    localparam logic [4:0] OP_SGE     = 5'd27;
    localparam logic [4:0] OP_ULT     = 5'd28;
    localparam logic [4:0] OP_ULE     = 5'd29;
    localparam logic [4:0] OP_UGT     = 5'd30;
    localparam logic [4:0] OP_UGE     = 5'd31;

    localparam logic [1:0] SEL_SIMPLE = 2'd0;
    localparam logic [1:0] SEL_MUL    = 2'd1;
    localparam logic [1:0] SEL_DIV    = 2'd2;

    localparam int DIV_STAGES = 64;
    localparam int LATENCY    = DIV_STAGES + 1;

    typedef struct packed {
        logic [1:0]  sel;
        logic        status;
        logic [1:0]  dt;
        logic [63:0] simple;
    } side_t;

    function automatic logic [63:0] width_mask(input logic [1:0] t);
        logic [63:0] m;
        unique case (t)
            2'd0: m = 64'h0000_0000_0000_00FF;
            2'd1: m = 64'h0000_0000_0000_FFFF;
            2'd2: m = 64'h0000_0000_FFFF_FFFF;
            default: m = '1;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] sign_ext(input logic [63:0] x, input logic [1:0] t);
        logic [63:0] r;
        unique case (t)
            2'd0: r = {{56{x[7]}}, x[7:0]};
            2'd1: r = {{48{x[15]}}, x[15:0]};
            2'd2: r = {{32{x[31]}}, x[31:0]};
            default: r = x;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/typed_integer_alu_unit.sv =====
// Typed integer ALU: decode stage, 64-stage divider, multiplier, output register
// done rises after the decode register, the 64 divider stages and the output
// register; the divider path sets this depth.
// Throughput: one item per cycle for every operation; busy is always low.
// Reset clears all valid bits; items in flight are dropped.
module typed_integer_alu_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tai_pkg::in_item_t   request,
    output logic                done,
    output tai_pkg::out_item_t  response
);

    logic            st_valid [tai_pkg::DIV_STAGES];
    tai_pkg::side_t  st_side  [tai_pkg::DIV_STAGES];
    logic [63:0]     st_rem   [tai_pkg::DIV_STAGES];
    logic [63:0]     st_quo   [tai_pkg::DIV_STAGES];
    logic [63:0]     st_div   [tai_pkg::DIV_STAGES];

    logic            dec_valid;
    tai_pkg::side_t  dec_side;
    logic [63:0]     dec_au, dec_bu, mul_prod;
    logic [63:0]     mul_dly_reg [tai_pkg::DIV_STAGES-2];

    logic                done_reg;
    tai_pkg::out_item_t  response_reg, response_next;

    tai_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .valid   (dec_valid),
        .side    (dec_side),
        .au      (dec_au),
        .bu      (dec_bu)
    );

    tai_mul u_mul (
        .clk  (clk),
        .a    (dec_au),
        .b    (dec_bu),
        .prod (mul_prod)
    );

    always_ff @(posedge clk)
    begin
        mul_dly_reg[0] <= mul_prod;
        for (int i = 1; i < tai_pkg::DIV_STAGES-2; i++)
            mul_dly_reg[i] <= mul_dly_reg[i-1];
    end

    tai_div_stage u_div_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (dec_valid),
        .side_in   (dec_side),
        .rem_in    (64'd0),
        .quo_in    (dec_au),
        .div_in    (dec_bu),
        .valid_out (st_valid[0]),
        .side_out  (st_side[0]),
        .rem_out   (st_rem[0]),
        .quo_out   (st_quo[0]),
        .div_out   (st_div[0])
    );

    for (genvar g = 1; g < tai_pkg::DIV_STAGES; g++)
    begin : g_div
        tai_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (st_valid[g-1]),
            .side_in   (st_side[g-1]),
            .rem_in    (st_rem[g-1]),
            .quo_in    (st_quo[g-1]),
            .div_in    (st_div[g-1]),
            .valid_out (st_valid[g]),
            .side_out  (st_side[g]),
            .rem_out   (st_rem[g]),
            .quo_out   (st_quo[g]),
            .div_out   (st_div[g])
        );
    end

    always_comb
    begin
        tai_pkg::side_t s;
        logic [63:0]    r;
        s = st_side[tai_pkg::DIV_STAGES-1];
        unique case (s.sel)
            tai_pkg::SEL_MUL: r = mul_dly_reg[tai_pkg::DIV_STAGES-3];
            tai_pkg::SEL_DIV: r = st_quo[tai_pkg::DIV_STAGES-1];
            default:          r = s.simple;
        endcase
        response_next.status       = s.status;
        response_next.result_value = s.status ? 64'd0 : (r & tai_pkg::width_mask(s.dt));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= st_valid[tai_pkg::DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        response_reg <= response_next;
    end

    assign busy     = 1'b0;
    assign done     = done_reg;
    assign response = response_reg;

endmodule

// ===== sv/tai_decode.sv =====
// Operand extension and the simple operations, registered
module tai_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  tai_pkg::in_item_t  request,
    output logic               valid,
    output tai_pkg::side_t     side,
    output logic [63:0]        au,
    output logic [63:0]        bu
);

    logic              valid_reg;
    tai_pkg::side_t    side_reg, side_next;
    logic [63:0]       au_reg, au_next, bu_reg, bu_next;

    always_comb
    begin
        logic [63:0] as, bs, r, sw;
        logic [5:0]  sh;
        logic        st;
        as = tai_pkg::sign_ext(request.a_value, request.a_type);
        bs = tai_pkg::sign_ext(request.b_value, request.b_type);
        au_next = request.a_value & tai_pkg::width_mask(request.a_type);
        bu_next = request.b_value & tai_pkg::width_mask(request.b_type);
        unique case (request.dest_type)
            2'd0: sh = bu_next[5:0] & 6'd7;
            2'd1: sh = bu_next[5:0] & 6'd15;
            2'd2: sh = bu_next[5:0] & 6'd31;
            default: sh = bu_next[5:0];
        endcase
        unique case (request.dest_type)
            2'd0: sw = {56'd0, au_next[7:0]};
            2'd1: sw = {48'd0, au_next[7:0], au_next[15:8]};
            2'd2: sw = {32'd0, au_next[7:0], au_next[15:8], au_next[23:16], au_next[31:24]};
            default:
            begin
                for (int i = 0; i < 8; i++)
                    sw[8*(7-i) +: 8] = au_next[8*i +: 8];
            end
        endcase
        r  = '0;
        st = 1'b0;
        side_next.sel = tai_pkg::SEL_SIMPLE;
        unique case (request.op)
            tai_pkg::OP_ASSIGN, tai_pkg::OP_CAST:
            begin
                if (request.a_type != request.dest_type)
                    st = 1'b1;
                else
                    r = request.a_value;
            end
            tai_pkg::OP_ZEXT, tai_pkg::OP_TRUNC: r = au_next;
            tai_pkg::OP_SEXT:    r = as;
            tai_pkg::OP_NEG:     r = 64'd0 - as;
            tai_pkg::OP_ABS:     r = as[63] ? 64'd0 - as : as;
            tai_pkg::OP_NOT:     r = ~au_next;
            tai_pkg::OP_BSWAP:   r = sw;
            tai_pkg::OP_ISTRUE:  r = {63'd0, au_next != 64'd0};
            tai_pkg::OP_ISFALSE: r = {63'd0, au_next == 64'd0};
            tai_pkg::OP_ADD:     r = au_next + bu_next;
            tai_pkg::OP_SUB:     r = au_next - bu_next;
            tai_pkg::OP_MUL:     side_next.sel = tai_pkg::SEL_MUL;
            tai_pkg::OP_UDIV:
            begin
                side_next.sel = tai_pkg::SEL_DIV;
                st = (bu_next == 64'd0);
            end
            tai_pkg::OP_AND:     r = au_next & bu_next;
            tai_pkg::OP_ANDNOT:  r = au_next & ~bu_next;
            tai_pkg::OP_OR:      r = au_next | bu_next;
            tai_pkg::OP_XOR:     r = au_next ^ bu_next;
            tai_pkg::OP_SHL:     r = au_next << sh;
            tai_pkg::OP_SHR:     r = au_next >> sh;
            tai_pkg::OP_SHA:     r = $unsigned($signed(as) >>> sh);
            tai_pkg::OP_EQ:      r = {63'd0, au_next == bu_next};
            tai_pkg::OP_NE:      r = {63'd0, au_next != bu_next};
            tai_pkg::OP_SLT:     r = {63'd0, $signed(as) <  $signed(bs)};
            tai_pkg::OP_SLE:     r = {63'd0, $signed(as) <= $signed(bs)};
            tai_pkg::OP_SGT:     r = {63'd0, $signed(as) >  $signed(bs)};
            tai_pkg::OP_SGE:     r = {63'd0, $signed(as) >= $signed(bs)};
            tai_pkg::OP_ULT:     r = {63'd0, au_next <  bu_next};
            tai_pkg::OP_ULE:     r = {63'd0, au_next <= bu_next};
            tai_pkg::OP_UGT:     r = {63'd0, au_next >  bu_next};
            default:             r = {63'd0, au_next >= bu_next};
        endcase
        side_next.status = st;
        side_next.dt     = request.dest_type;
        side_next.simple = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
        au_reg   <= au_next;
        bu_reg   <= bu_next;
    end

    assign valid = valid_reg;
    assign side  = side_reg;
    assign au    = au_reg;
    assign bu    = bu_reg;

endmodule

// ===== sv/tai_mul.sv =====
// Two-stage 64-bit low-half multiplier from 32x32 partial products
module tai_mul (
    input  logic        clk,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] prod
);

    logic [63:0] ll_reg;
    logic [31:0] lh_reg, hl_reg;
    logic [63:0] prod_reg, prod_next;

    always_comb
    begin
        logic [31:0] cross_sum;
        cross_sum = lh_reg + hl_reg;
        prod_next = ll_reg + {cross_sum, 32'd0};
    end

    always_ff @(posedge clk)
    begin
        ll_reg   <= 64'(a[31:0] * b[31:0]);
        lh_reg   <= 32'(a[31:0] * b[63:32]);
        hl_reg   <= 32'(a[63:32] * b[31:0]);
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== sv/tai_div_stage.sv =====
// One restoring-division step: one quotient bit per stage
module tai_div_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            valid_in,
    input  tai_pkg::side_t  side_in,
    input  logic [63:0]     rem_in,
    input  logic [63:0]     quo_in,
    input  logic [63:0]     div_in,
    output logic            valid_out,
    output tai_pkg::side_t  side_out,
    output logic [63:0]     rem_out,
    output logic [63:0]     quo_out,
    output logic [63:0]     div_out
);

    logic            valid_reg;
    tai_pkg::side_t  side_reg;
    logic [63:0]     rem_reg, rem_next, quo_reg, quo_next, div_reg;

    always_comb
    begin
        logic [64:0] trial, diff;
        trial = {rem_in, quo_in[63]};
        diff  = trial - {1'b0, div_in};
        if (!diff[64])
        begin
            rem_next = diff[63:0];
            quo_next = {quo_in[62:0], 1'b1};
        end
        else
        begin
            rem_next = trial[63:0];
            quo_next = {quo_in[62:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_in;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        div_reg  <= div_in;
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;
    assign div_out   = div_reg;

endmodule

// ===== sv/tai_checker.sv =====
// Port-level assertions for the typed integer ALU, bound to the top level
`include "typed_integer_alu_unit_macros.svh"

module tai_port_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  tai_pkg::in_item_t   request,
    input  logic                done,
    input  tai_pkg::out_item_t  response
);

    logic err_op;
    logic err_out;

    assign err_op  = (request.op == tai_pkg::OP_UDIV) || (request.op == tai_pkg::OP_ASSIGN)
                     || (request.op == tai_pkg::OP_CAST);
    assign err_out = done && response.status;

    `TAI_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
    `TAI_ASSERT(a_latency, start |-> ##66 done, "item did not complete on time")
    `TAI_ASSERT(a_err_zero, err_out |-> (response.result_value == 64'd0), "error item carries data")
    `TAI_ASSERT(a_err_cause, err_out |-> $past(err_op, 66), "error from wrong op")

endmodule

bind typed_integer_alu_unit tai_port_checker u_tai_checker (.*);
